// ----- hw/rtl/srect_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package srect_pkg;

  // Field widths
  localparam int COORD_W = 24;
  localparam int EXT_W   = COORD_W - 2;
  // Differences reach one corner past the box: two extra bits of range
  localparam int DIFF_W  = COORD_W + 2;
  localparam int PROD_W  = 2 * DIFF_W;

  localparam int IN_FIELDS_W = 6 * COORD_W + 2 * EXT_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [EXT_W-1:0]   extent_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  // Captured input beat
  typedef struct packed {
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
    coord_t  box_x;
    coord_t  box_y;
    extent_t box_width;
    extent_t box_height;
  } in_item_t;

  // Differences and early flags
  typedef struct packed {
    diff_t      sx;
    diff_t      sy;
    diff_t      sy_n;
    diff_t      ox0;
    diff_t      oy0;
    diff_t      ox1;
    diff_t      oy1;
    diff_t      w;
    diff_t      h;
    logic [3:0] edge_ok;
    logic       pt_hit;
  } diff_stage_t;

  // Cross products and carried flags
  typedef struct packed {
    prod_t      p_sx_oy0;
    prod_t      p_sy_ox0;
    prod_t      p_sx_oy1;
    prod_t      p_sy_ox1;
    prod_t      h_sx;
    prod_t      w_sy_n;
    logic [3:0] edge_ok;
    logic       pt_hit;
  } prod_stage_t;

  // True when num/den lies in [0,1]; a zero denominator never passes
  function automatic logic in_unit(input prod_t num, input prod_t den);
    logic res;
    if (den == '0) begin
      res = 1'b0;
    end else if (den > 0) begin
      res = (num >= 0) && (num <= den);
    end else begin
      res = (num <= 0) && (num >= den);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/segment_rect_intersect_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Segment versus axis-aligned rectangle hit test. Each input beat carries one
// segment and one rectangle (signed Q15.8 corner, unsigned Q14.8 size); each
// output beat carries one hit flag, set when the segment crosses a rectangle
// edge or either endpoint lies in the closed rectangle. The test is exact: no
// rounding or saturation. The block takes one pair per clock while out_tready keeps
// the pipeline moving; each pair passes four registered stages: an input register,
// a stage of coordinate differences, a stage of six parallel 26x26 products,
// and the output register holding the final compare. Every stage has its own
// valid bit, so bubbles are squeezed out and input beats are taken while a
// result waits at the output.
module segment_rect_intersect_core (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // start_x, start_y, end_x, end_y, box_x, box_y, box_width, box_height, pad
  input  wire [srect_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // hit, pad
  output logic [srect_pkg::OUT_DATA_W-1:0] out_tdata
);
  import srect_pkg::*;

  logic        s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  in_item_t    s1_r;
  diff_stage_t s2_r, s2_nxt;
  prod_stage_t s3_r, s3_nxt;
  logic        hit_r, hit_nxt;
  logic        out_rdy, s3_rdy, s2_rdy;
  in_item_t    in_item;

  // Ready chain: a stage takes data when empty or when it drains
  assign out_rdy   = !out_valid_r || out_tready;
  assign s3_rdy    = !s3_valid_r || out_rdy;
  assign s2_rdy    = !s2_valid_r || s3_rdy;
  assign in_tready = !s1_valid_r || s2_rdy;

  // Unpack input beat, first field in the low bits
  always_comb begin
    in_item.start_x    = coord_t'(in_tdata[0*COORD_W +: COORD_W]);
    in_item.start_y    = coord_t'(in_tdata[1*COORD_W +: COORD_W]);
    in_item.end_x      = coord_t'(in_tdata[2*COORD_W +: COORD_W]);
    in_item.end_y      = coord_t'(in_tdata[3*COORD_W +: COORD_W]);
    in_item.box_x      = coord_t'(in_tdata[4*COORD_W +: COORD_W]);
    in_item.box_y      = coord_t'(in_tdata[5*COORD_W +: COORD_W]);
    in_item.box_width  = in_tdata[6*COORD_W +: EXT_W];
    in_item.box_height = in_tdata[6*COORD_W + EXT_W +: EXT_W];
  end

  // Differences, parameter range of each edge along the segment, point tests
  always_comb begin
    diff_t ax, ay, bx, by, x0, y0, x1, y1;
    ax = diff_t'(s1_r.start_x);
    ay = diff_t'(s1_r.start_y);
    bx = diff_t'(s1_r.end_x);
    by = diff_t'(s1_r.end_y);
    x0 = diff_t'(s1_r.box_x);
    y0 = diff_t'(s1_r.box_y);
    s2_nxt.w = diff_t'({2'b00, s1_r.box_width});
    s2_nxt.h = diff_t'({2'b00, s1_r.box_height});
    x1 = x0 + s2_nxt.w;
    y1 = y0 + s2_nxt.h;

    s2_nxt.sx   = bx - ax;
    s2_nxt.sy   = by - ay;
    s2_nxt.sy_n = ay - by;
    s2_nxt.ox0  = ax - x0;
    s2_nxt.oy0  = ay - y0;
    s2_nxt.ox1  = ax - x1;
    s2_nxt.oy1  = ay - y1;

    // Left, top, bottom, right edge: crossing parameter on the segment
    s2_nxt.edge_ok[0] = (s2_nxt.h != '0) &&
                        in_unit(prod_t'(-s2_nxt.ox0), prod_t'(s2_nxt.sx));
    s2_nxt.edge_ok[1] = (s2_nxt.w != '0) &&
                        in_unit(prod_t'(-s2_nxt.oy0), prod_t'(s2_nxt.sy));
    s2_nxt.edge_ok[2] = (s2_nxt.w != '0) &&
                        in_unit(prod_t'(-s2_nxt.oy1), prod_t'(s2_nxt.sy));
    s2_nxt.edge_ok[3] = (s2_nxt.h != '0) &&
                        in_unit(prod_t'(-s2_nxt.ox1), prod_t'(s2_nxt.sx));

    s2_nxt.pt_hit = (ax >= x0 && ax <= x1 && ay >= y0 && ay <= y1) ||
                    (bx >= x0 && bx <= x1 && by >= y0 && by <= y1);
  end

  // Cross products
  always_comb begin
    s3_nxt.p_sx_oy0 = s2_r.sx * s2_r.oy0;
    s3_nxt.p_sy_ox0 = s2_r.sy * s2_r.ox0;
    s3_nxt.p_sx_oy1 = s2_r.sx * s2_r.oy1;
    s3_nxt.p_sy_ox1 = s2_r.sy * s2_r.ox1;
    s3_nxt.h_sx     = s2_r.h * s2_r.sx;
    s3_nxt.w_sy_n   = s2_r.w * s2_r.sy_n;
    s3_nxt.edge_ok  = s2_r.edge_ok;
    s3_nxt.pt_hit   = s2_r.pt_hit;
  end

  // Crossing parameter along each edge, then combine
  always_comb begin
    prod_t nb_near, nb_bottom, nb_right;
    nb_near   = s3_r.p_sx_oy0 - s3_r.p_sy_ox0;
    nb_bottom = s3_r.p_sx_oy1 - s3_r.p_sy_ox0;
    nb_right  = s3_r.p_sx_oy0 - s3_r.p_sy_ox1;
    hit_nxt = s3_r.pt_hit ||
              (s3_r.edge_ok[0] && in_unit(nb_near, s3_r.h_sx)) ||
              (s3_r.edge_ok[1] && in_unit(nb_near, s3_r.w_sy_n)) ||
              (s3_r.edge_ok[2] && in_unit(nb_bottom, s3_r.w_sy_n)) ||
              (s3_r.edge_ok[3] && in_unit(nb_right, s3_r.h_sx));
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r  <= in_tvalid;
      if (s2_rdy)    s2_valid_r  <= s1_valid_r;
      if (s3_rdy)    s3_valid_r  <= s2_valid_r;
      if (out_rdy)   out_valid_r <= s3_valid_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_r  <= in_item;
    if (s2_rdy && s1_valid_r)   s2_r  <= s2_nxt;
    if (s3_rdy && s2_valid_r)   s3_r  <= s3_nxt;
    if (out_rdy && s3_valid_r)  hit_r <= hit_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, hit_r};

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

  // With the output stage empty the pipeline always takes a beat
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output stage");

  // A finished product stage reaches the output when it may move
  a_s3_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && out_rdy) |=> out_valid_r)
    else $error("result lost between product stage and output");

  // A stalled input stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_rdy) |=> (s1_valid_r && $stable(s1_r)))
    else $error("input stage item changed while stalled");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import srect_pkg::*;

  localparam int RESET_CYCLES  = 10;
  localparam int N_RANDOM      = 1928;
  localparam int N_PHASES      = 8;
  localparam int HOLD_AT       = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;

  localparam longint C_MAX   = 8388607;
  localparam longint C_MIN   = -8388608;
  localparam longint EXT_MAX = 4194303;

  typedef enum {PREDICT, EXPECT_MISS, EXPECT_HIT} row_check_t;

  typedef struct {
    in_item_t   item;
    row_check_t check;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  bit          hit_expected[$];
  int          fail_count = 0;
  int          items_sent = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;

  stim_row_t   dir_rows [0:22];

  segment_rect_intersect_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // num/den within [0,1]; a zero denominator never passes
  function automatic bit ratio_in_unit(longint num, longint den);
    if (den == 0) return 1'b0;
    if (den > 0) return (num >= 0) && (num <= den);
    return (num <= 0) && (num >= den);
  endfunction

  // Segment a-b against rectangle side c-d, exact cross products
  function automatic bit side_crossed(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy, longint dx, longint dy);
    longint ex, ey, sx, sy, ox, oy, den, na, nb;
    ex  = dx - cx;
    ey  = dy - cy;
    sx  = bx - ax;
    sy  = by - ay;
    ox  = ax - cx;
    oy  = ay - cy;
    den = ey * sx - ex * sy;
    na  = ex * oy - ey * ox;
    nb  = sx * oy - sy * ox;
    return ratio_in_unit(na, den) && ratio_in_unit(nb, den);
  endfunction

  function automatic bit point_in_box(longint px, longint py, longint x0, longint y0,
                                      longint x1, longint y1);
    return (px >= x0) && (px <= x1) && (py >= y0) && (py <= y1);
  endfunction

  // Hit flag for one segment and rectangle; far corner formed without wrap
  function automatic bit segment_hits_box(in_item_t it);
    longint ax, ay, bx, by, x0, y0, x1, y1;
    ax = it.start_x;
    ay = it.start_y;
    bx = it.end_x;
    by = it.end_y;
    x0 = it.box_x;
    y0 = it.box_y;
    x1 = x0 + longint'(it.box_width);
    y1 = y0 + longint'(it.box_height);
    return side_crossed(ax, ay, bx, by, x0, y0, x0, y1) ||
           side_crossed(ax, ay, bx, by, x0, y0, x1, y0) ||
           side_crossed(ax, ay, bx, by, x0, y1, x1, y1) ||
           side_crossed(ax, ay, bx, by, x1, y0, x1, y1) ||
           point_in_box(ax, ay, x0, y0, x1, y1) ||
           point_in_box(bx, by, x0, y0, x1, y1);
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_beat(in_item_t it);
    logic [IN_DATA_W-1:0] beat;
    beat = '0;
    beat[IN_FIELDS_W-1:0] = {it.box_height, it.box_width, it.box_y, it.box_x,
                             it.end_y, it.end_x, it.start_y, it.start_x};
    return beat;
  endfunction

  function automatic stim_row_t mk_row(longint sx, longint sy, longint ex, longint ey,
                                       longint bx, longint by, longint w, longint h,
                                       row_check_t chk);
    stim_row_t r;
    r.item.start_x    = coord_t'(sx);
    r.item.start_y    = coord_t'(sy);
    r.item.end_x      = coord_t'(ex);
    r.item.end_y      = coord_t'(ey);
    r.item.box_x      = coord_t'(bx);
    r.item.box_y      = coord_t'(by);
    r.item.box_width  = extent_t'(w);
    r.item.box_height = extent_t'(h);
    r.check           = chk;
    return r;
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > C_MAX) return coord_t'(C_MAX);
    if (v < C_MIN) return coord_t'(C_MIN);
    return coord_t'(v);
  endfunction

  // Value on, or one off, either bound; sometimes anywhere near the span
  function automatic coord_t near_side(longint lo, longint hi);
    longint v;
    case ($urandom_range(6))
      0: v = lo - 1;
      1: v = lo;
      2: v = lo + 1;
      3: v = hi - 1;
      4: v = hi;
      5: v = hi + 1;
      default: v = lo - 50 + longint'($urandom_range(int'(hi - lo) + 100));
    endcase
    return clamp_coord(v);
  endfunction

  function automatic coord_t around(longint base, longint span);
    return clamp_coord(base - span / 2 + longint'($urandom_range(int'(2 * span))));
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(6))
      0: return coord_t'(C_MIN);
      1: return coord_t'(C_MIN + 1);
      2: return coord_t'(-1);
      3: return coord_t'(0);
      4: return coord_t'(1);
      5: return coord_t'(C_MAX - 1);
      default: return coord_t'(C_MAX);
    endcase
  endfunction

  function automatic extent_t extreme_extent();
    case ($urandom_range(3))
      0: return extent_t'(0);
      1: return extent_t'(1);
      2: return extent_t'(EXT_MAX - 1);
      default: return extent_t'(EXT_MAX);
    endcase
  endfunction

  // Mix of local geometry, side-aligned cases, full-range bits and extremes
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    longint      x0, y0, w, h;
    pick = $urandom_range(99);
    x0 = longint'($urandom_range(4000)) - 2000;
    y0 = longint'($urandom_range(4000)) - 2000;
    w  = ($urandom_range(7) == 0) ? 0 : longint'($urandom_range(1000));
    h  = ($urandom_range(7) == 0) ? 0 : longint'($urandom_range(1000));
    it.box_x      = coord_t'(x0);
    it.box_y      = coord_t'(y0);
    it.box_width  = extent_t'(w);
    it.box_height = extent_t'(h);
    if (pick < 40) begin
      it.start_x = coord_t'(longint'($urandom_range(6000)) - 3000);
      it.start_y = coord_t'(longint'($urandom_range(6000)) - 3000);
      it.end_x   = coord_t'(longint'($urandom_range(6000)) - 3000);
      it.end_y   = coord_t'(longint'($urandom_range(6000)) - 3000);
    end else if (pick < 60) begin
      it.start_x = near_side(x0, x0 + w);
      it.start_y = near_side(y0, y0 + h);
      it.end_x   = near_side(x0, x0 + w);
      it.end_y   = near_side(y0, y0 + h);
    end else if (pick < 75) begin
      it.start_x    = coord_t'($urandom());
      it.start_y    = coord_t'($urandom());
      it.end_x      = coord_t'($urandom());
      it.end_y      = coord_t'($urandom());
      it.box_x      = coord_t'($urandom());
      it.box_y      = coord_t'($urandom());
      it.box_width  = extent_t'($urandom());
      it.box_height = extent_t'($urandom());
    end else if (pick < 90) begin
      it.box_x      = coord_t'($urandom());
      it.box_y      = coord_t'($urandom());
      it.box_width  = extent_t'($urandom());
      it.box_height = extent_t'($urandom());
      it.start_x    = around(longint'(it.box_x), longint'(it.box_width));
      it.start_y    = around(longint'(it.box_y), longint'(it.box_height));
      it.end_x      = around(longint'(it.box_x), longint'(it.box_width));
      it.end_y      = around(longint'(it.box_y), longint'(it.box_height));
    end else begin
      it.start_x    = extreme_coord();
      it.start_y    = extreme_coord();
      it.end_x      = extreme_coord();
      it.end_y      = extreme_coord();
      it.box_x      = extreme_coord();
      it.box_y      = extreme_coord();
      it.box_width  = extreme_extent();
      it.box_height = extreme_extent();
    end
    return it;
  endfunction

  // Offer one beat after a random gap; record its hit flag once taken
  task automatic send_item(input in_item_t it, input bit want_hit);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_beat(it);
    do @(posedge clk); while (!in_tready);
    hit_expected.push_back(want_hit);
    items_sent++;
    @(negedge clk);
  endtask

  // Drive result ready; hold off once for a long stretch to back up the pipe
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && items_sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result beat with the oldest pending hit flag
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (hit_expected.size() == 0) begin
        $error("hit: unexpected result beat, actual %0d", out_tdata[0]);
        fail_count++;
      end else begin
        if (out_tdata[0] !== hit_expected[0]) begin
          $error("hit mismatch: expected %0d, actual %0d", hit_expected[0], out_tdata[0]);
          fail_count++;
        end
        void'(hit_expected.pop_front());
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    int       drain;
    bit       want_hit;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed cases: zero sizes, touching sides, parallel runs, full-range extremes
    dir_rows = '{
      mk_row(0, 0, 0, 0, 0, 0, 0, 0, EXPECT_HIT),
      mk_row(10, 10, 20, 20, 0, 0, 1000, 1000, EXPECT_HIT),
      mk_row(-100, -100, -50, -100, 0, 0, 10, 10, EXPECT_MISS),
      mk_row(-10, 5, 20, 5, 0, 0, 10, 10, EXPECT_HIT),
      mk_row(-5, 5, 5, -5, 0, 0, 10, 10, PREDICT),
      mk_row(-5, 0, 15, 0, 0, 0, 10, 10, PREDICT),
      mk_row(-20, 0, -5, 0, 0, 0, 10, 10, PREDICT),
      mk_row(-5, 5, 5, 5, 0, 0, 0, 10, PREDICT),
      mk_row(-5, -5, 5, 5, 0, 0, 0, 0, PREDICT),
      mk_row(20, 20, 20, 20, 0, 0, 10, 10, EXPECT_MISS),
      mk_row(5, 5, 5, 5, 0, 0, 10, 10, EXPECT_HIT),
      mk_row(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, EXT_MAX, EXT_MAX, EXPECT_HIT),
      mk_row(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, EXT_MAX, EXT_MAX, EXPECT_HIT),
      mk_row(C_MIN, C_MIN, C_MAX, C_MAX, 0, 0, 100, 100, PREDICT),
      mk_row(C_MAX, 5, C_MAX, 5, 8388000, 0, EXT_MAX, 10, EXPECT_HIT),
      mk_row(-5000000, 5, -5000000, 5, 8388000, 0, EXT_MAX, 10, EXPECT_MISS),
      mk_row(10, 10, 30, 30, 0, 0, 10, 10, EXPECT_HIT),
      mk_row(-10, 5, -1, 5, 0, 0, 10, 10, EXPECT_MISS),
      mk_row(-1, -1, -1, -1, -1, -1, EXT_MAX, EXT_MAX, EXPECT_HIT),
      mk_row(-5592406, 5592405, 5592405, -5592406, -5592406, -5592406,
             2796202, 1398101, PREDICT),
      mk_row(-1, -1, 11, 11, 0, 0, 10, 10, EXPECT_HIT),
      mk_row(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, EXT_MAX, EXT_MAX, PREDICT),
      mk_row(-10, 20, 20, -10, 0, 0, 10, 10, PREDICT)
    };

    foreach (dir_rows[i]) begin
      case (dir_rows[i].check)
        EXPECT_HIT:  want_hit = 1'b1;
        EXPECT_MISS: want_hit = 1'b0;
        default:     want_hit = segment_hits_box(dir_rows[i].item);
      endcase
      send_item(dir_rows[i].item, want_hit);
    end

    // Random part, cycling through the idle and stall mixes
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      repeat (N_RANDOM / N_PHASES) begin
        it = random_item();
        send_item(it, segment_hits_box(it));
      end
    end
    in_tvalid <= 1'b0;

    // Drain outstanding results, then watch for stray beats
    drain = 0;
    while (hit_expected.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (hit_expected.size() != 0) begin
      $error("hit: %0d results never arrived", hit_expected.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
